// ----- hw/rtl/sdnw_pkg.sv -----
// ----------------------------------------------------------------------------
// sdnw_pkg
// Shared types, constants and the segment lookup for the number writer.
// ----------------------------------------------------------------------------
`default_nettype none

package sdnw_pkg;

  localparam int DISPLAY_CELLS_DEF = 10;
  localparam int NUM_W             = 14;
  localparam int CELL_W            = 3;
  localparam int NIB_W             = 4;
  localparam int DIGITS            = 4;
  localparam int WRITES_PER_CELL   = 3;

  localparam logic [NUM_W-1:0] NUM_MAX    = 14'd9999;
  localparam logic [12:0]      RECIP_TEN  = 13'd6554;
  localparam int               RECIP_SHFT = 16;

  typedef enum logic [1:0] {
    PH_ADDR = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [NUM_W-1:0]  number_value;
    logic [CELL_W-1:0] start_cell;
  } in_item_t;

  typedef struct packed {
    logic             is_address_write;
    logic [NIB_W-1:0] bus_nibble;
    logic             last_write;
  } out_item_t;

  typedef struct packed {
    logic [DIGITS-1:0][NIB_W-1:0] digits;
    logic [CELL_W-1:0]            pos;
  } job_t;

  function automatic logic [7:0] seg_lookup(input logic [NIB_W-1:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'b11101110;
      4'd1:    seg = 8'b00000110;
      4'd2:    seg = 8'b11110010;
      4'd3:    seg = 8'b11010110;
      4'd4:    seg = 8'b00011110;
      4'd5:    seg = 8'b11011100;
      4'd6:    seg = 8'b11111100;
      4'd7:    seg = 8'b10000110;
      4'd8:    seg = 8'b11111110;
      4'd9:    seg = 8'b11011110;
      default: seg = 8'b00000000;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sdnw_front.sv -----
// ----------------------------------------------------------------------------
// sdnw_front
// Accepts numbers, saturates and clamps, splits into four decimal digits.
// ----------------------------------------------------------------------------
`default_nettype none

module sdnw_front #(
  parameter int DISPLAY_CELLS = sdnw_pkg::DISPLAY_CELLS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sdnw_pkg::in_item_t in_data,
  output logic                   push,
  output sdnw_pkg::job_t         push_job,
  input  wire logic              q_full
);
  import sdnw_pkg::*;

  localparam logic [4:0] MAX_POS = 5'(DISPLAY_CELLS - DIGITS);

  logic              busy_r, busy_nxt;
  logic [1:0]        step_r, step_nxt;
  logic [NUM_W-1:0]  val_r, val_nxt;
  logic [CELL_W-1:0] pos_r, pos_nxt;
  logic [DIGITS-1:0][NIB_W-1:0] dig_r, dig_nxt;

  logic [26:0]      prod;
  logic [NUM_W-1:0] quot;
  logic [NUM_W-1:0] rem;
  logic             last_step;
  logic             accept;

  assign prod      = 27'(val_r) * 27'(RECIP_TEN);
  assign quot      = NUM_W'(prod[26:RECIP_SHFT]);
  assign rem       = val_r - ((quot << 3) + (quot << 1));
  assign last_step = busy_r && (step_r == 2'd3);
  assign push      = last_step && !q_full;
  assign in_stall  = busy_r && !push;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    push_job.digits        = dig_r;
    push_job.digits[3]     = rem[NIB_W-1:0];
    push_job.pos           = pos_r;
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    val_nxt  = val_r;
    pos_nxt  = pos_r;
    dig_nxt  = dig_r;
    if (busy_r && !last_step) begin
      dig_nxt[step_r] = rem[NIB_W-1:0];
      val_nxt         = quot;
      step_nxt        = step_r + 2'd1;
    end
    if (push) begin
      busy_nxt = 1'b0;
    end
    if (accept) begin
      busy_nxt = 1'b1;
      step_nxt = 2'd0;
      val_nxt  = (in_data.number_value > NUM_MAX) ? NUM_MAX : in_data.number_value;
      pos_nxt  = ({2'b00, in_data.start_cell} > MAX_POS) ? MAX_POS[CELL_W-1:0]
                                                         : in_data.start_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    val_r <= val_nxt;
    pos_r <= pos_nxt;
    dig_r <= dig_nxt;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sdnw_queue.sv -----
// ----------------------------------------------------------------------------
// sdnw_queue
// Two-entry queue of digit jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module sdnw_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire sdnw_pkg::job_t  push_job,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output sdnw_pkg::job_t       head
);
  import sdnw_pkg::*;

  job_t       mem_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign head    = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_nxt  = do_push ? !wr_r : wr_r;
    rd_nxt  = do_pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sdnw_back.sv -----
// ----------------------------------------------------------------------------
// sdnw_back
// Sequences the twelve bus writes of each job into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdnw_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              empty,
  input  wire sdnw_pkg::job_t    head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sdnw_pkg::out_item_t    out_data
);
  import sdnw_pkg::*;

  logic      [1:0] idx_r, idx_nxt;
  phase_t          ph_r, ph_nxt;
  logic            vld_r, vld_nxt;
  out_item_t       dat_r, dat_nxt;

  logic             adv;
  logic             fire;
  logic [7:0]       seg;
  logic [NIB_W-1:0] cell_addr;
  logic             last;

  assign adv       = !vld_r || !out_stall;
  assign fire      = adv && !empty;
  assign seg       = seg_lookup(head.digits[idx_r]);
  assign cell_addr = NIB_W'(head.pos) + NIB_W'(2'd3 - idx_r);
  assign last      = (idx_r == 2'd3) && (ph_r == PH_LOW);
  assign pop       = fire && last;
  assign out_valid = vld_r;
  assign out_data  = dat_r;

  always_comb begin
    idx_nxt = idx_r;
    ph_nxt  = ph_r;
    vld_nxt = vld_r;
    dat_nxt = dat_r;
    if (adv) begin
      vld_nxt = !empty;
    end
    if (fire) begin
      dat_nxt.last_write = last;
      case (ph_r)
        PH_ADDR: begin
          dat_nxt.is_address_write = 1'b1;
          dat_nxt.bus_nibble       = cell_addr;
          ph_nxt                   = PH_HIGH;
        end
        PH_HIGH: begin
          dat_nxt.is_address_write = 1'b0;
          dat_nxt.bus_nibble       = seg[7:4];
          ph_nxt                   = PH_LOW;
        end
        default: begin
          dat_nxt.is_address_write = 1'b0;
          dat_nxt.bus_nibble       = seg[3:0];
          ph_nxt                   = PH_ADDR;
          idx_nxt                  = idx_r + 2'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      ph_r  <= PH_ADDR;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      ph_r  <= ph_nxt;
      vld_r <= vld_nxt;
    end
    dat_r <= dat_nxt;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/segment_display_number_writer_top.sv -----
// ----------------------------------------------------------------------------
// segment_display_number_writer_top
// Writes a four-digit number to a seven-segment display as nibble bus writes.
//
// Input channel (in_valid/in_stall/in_data) takes a 14-bit number and the
// cell for the thousands digit. Numbers above 9999 show as 9999; a start cell
// past DISPLAY_CELLS-4 is pulled back so all four cells fit.
// Output channel (out_valid/out_stall/out_data) gives twelve transactions per
// number: for units, tens, hundreds, thousands in turn, the cell address, the
// high segment nibble, the low segment nibble. last_write marks the twelfth.
// After acceptance the front extracts the digits, one reciprocal multiply per
// digit, and queues the job; the back end then registers each write in turn.
// Throughput is bounded by the single nibble output that carries every write.
// A two-entry job queue lets new numbers be taken while writes drain.
// A stalled output holds its transaction; backpressure fills the queue and
// then stalls the input. Reset (rst_n low, synchronous) empties everything.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_display_number_writer_top #(
  parameter int DISPLAY_CELLS = sdnw_pkg::DISPLAY_CELLS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire sdnw_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output sdnw_pkg::out_item_t      out_data
);
  import sdnw_pkg::*;

  logic push, q_full, pop, q_empty;
  job_t push_job, head;

  sdnw_front #(.DISPLAY_CELLS(DISPLAY_CELLS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  sdnw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  sdnw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
